>>> design/rwm_pkg.sv
// Shared types, constants and helpers of the RGB window median filter.
package rwm_pkg;

    // Defaults of the top-level size parameters
    localparam int MAX_KERNEL_DEF = 7;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CH_N      = 3;
    localparam int POS_W     = 10;
    localparam int KS_W      = 3;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Stream beat widths, padded to whole bytes
    localparam int IN_DATA_W  = ((CH_N * PIX_W + 7) / 8) * 8;
    localparam int OUT_USED_W = CH_N * PIX_W + 2 * POS_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [KS_W-1:0]  KS_RST     = 3'd3;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    // Position and frame mark of one result
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_tag;

    // One finished result
    typedef struct packed {
        t_tag                        tag;
        logic [CH_N-1:0][PIX_W-1:0]  med;
    } t_res;

    // Effective odd window side: zero acts as one, even rounds down, capped at top
    function automatic logic [3:0] odd_kernel(input logic [KS_W-1:0] ks,
                                              input logic [3:0] top);
        logic [3:0] k;
        k = {1'b0, ks};
        if (k == 4'd0) k = 4'd1;
        if (!k[0]) k = k - 4'd1;
        if (k > top) k = top;
        return k;
    endfunction

endpackage

>>> design/rgb_window_median_filter.sv
// Top level of the streaming per-channel 2-D median filter over BGR pixels.
//
// Input beats carry one pixel in raster order: tdata = blue, green, red bytes;
// tuser = frame start, which restarts row and column counting at zero.
// Output beats carry the channel medians of the k x k window around a centre,
// with the centre row and column; tlast marks the frame's last result.
// Border positions, whose window leaves the frame, give no output beat.
// Configuration (kernel size, width, height) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data while the stream is idle.
// Throughput: one pixel per clock while the output queue has space. Path from
// the input beat to the output beat: line-memory read, window shift, eight
// bit-select stages in each channel lane, and the output queue.
// Reset clears the position counters, the pipeline valids and the output
// queue and loads kernel 3, width 640, height 480; line stores hold whatever
// was there and need no clearing.
// When the receiver stalls, a two-entry output queue takes in-flight results;
// once it is full and not being drained, tready drops and the pipe holds.
module rgb_window_median_filter import rwm_pkg::*; #(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // pix_blue, pix_green, pix_red
    input  logic                  i_s_axis_tuser,   // frame_start
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // med_blue, med_green, med_red,
                                                    // center_row, center_col
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DIM_W-1:0]      i_cfg_data
);

    localparam int LINES = MAX_KERNEL - 1;
    localparam int KTOP  = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
    localparam int N     = KTOP * KTOP;
    localparam int CNW   = $clog2(N + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int AH    = $clog2(MAX_HEIGHT);
    localparam int SW    = $clog2(LINES);
    localparam int PXW   = CH_N * PIX_W;

    // configuration registers
    logic [KS_W-1:0]  r_ks;
    logic [DIM_W-1:0] r_iw;
    logic [DIM_W-1:0] r_ih;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks <= KS_RST;
            r_iw <= WIDTH_RST;
            r_ih <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL: r_ks <= i_cfg_data[KS_W-1:0];
                CFG_WIDTH:  r_iw <= i_cfg_data;
                CFG_HEIGHT: r_ih <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [3:0]  w_k;
    logic [3:0]  w_b;
    logic [3:0]  w_2b;
    logic [AW:0] w_w;
    logic [AH:0] w_h;

    assign w_k  = odd_kernel(r_ks, 4'(KTOP));
    assign w_b  = w_k >> 1;
    assign w_2b = w_k - 4'd1;

    always_comb begin
        if (r_iw == '0) w_w = (AW+1)'(1);
        else if (r_iw > MAX_WIDTH) w_w = (AW+1)'(MAX_WIDTH);
        else w_w = (AW+1)'(r_iw);
        if (r_ih == '0) w_h = (AH+1)'(1);
        else if (r_ih > MAX_HEIGHT) w_h = (AH+1)'(MAX_HEIGHT);
        else w_h = (AH+1)'(r_ih);
    end

    // handshake
    logic w_en;
    logic w_acc;

    assign o_s_axis_tready = w_en;
    assign w_acc = i_s_axis_tvalid && w_en;

    // position of the incoming pixel and of the next one
    logic [AW-1:0] r_col, n_col, w_col_in, w_c;
    logic [AH-1:0] r_row, n_row, w_row_in, w_r;
    logic [SW-1:0] r_slot, n_slot, w_slot_in, w_slot_a, w_slot;
    logic [AH:0]   w_row_a, w_r1;
    logic [AW:0]   w_c1;
    logic          w_emit;
    t_tag          w_tag;

    always_comb begin
        w_col_in  = i_s_axis_tuser ? '0 : r_col;
        w_row_in  = i_s_axis_tuser ? '0 : r_row;
        w_slot_in = i_s_axis_tuser ? '0 : r_slot;

        // a column at or past the width ends the line
        w_c      = w_col_in;
        w_row_a  = {1'b0, w_row_in};
        w_slot_a = w_slot_in;
        if ({1'b0, w_col_in} >= w_w) begin
            w_c      = '0;
            w_row_a  = {1'b0, w_row_in} + (AH+1)'(1);
            w_slot_a = (w_slot_in == SW'(LINES - 1)) ? '0 : w_slot_in + SW'(1);
        end
        if (w_row_a >= w_h) begin
            w_r    = '0;
            w_slot = '0;
        end else begin
            w_r    = w_row_a[AH-1:0];
            w_slot = w_slot_a;
        end

        // advance
        w_c1   = {1'b0, w_c} + (AW+1)'(1);
        w_r1   = {1'b0, w_r} + (AH+1)'(1);
        n_col  = w_c1[AW-1:0];
        n_row  = w_r;
        n_slot = w_slot;
        if (w_c1 >= w_w) begin
            n_col = '0;
            if (w_r1 >= w_h) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = w_r1[AH-1:0];
                n_slot = (w_slot == SW'(LINES - 1)) ? '0 : w_slot + SW'(1);
            end
        end

        w_emit   = ({1'b0, w_c} >= (AW+1)'(w_2b)) && ({1'b0, w_r} >= (AH+1)'(w_2b));
        w_tag.row  = POS_W'(w_r) - POS_W'(w_b);
        w_tag.col  = POS_W'(w_c) - POS_W'(w_b);
        w_tag.last = (w_c1 == w_w) && (w_r1 == w_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (w_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    // line stores
    logic [LINES-1:0][PXW-1:0] w_rdata;

    rwm_linebuf #(
        .LINES     (LINES),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_acc   (w_acc),
        .i_addr  (w_c),
        .i_wslot (w_slot),
        .i_wdata (i_s_axis_tdata[PXW-1:0]),
        .o_rdata (w_rdata)
    );

    // stage 1: memory data returns
    logic          r_s1_valid;
    logic          r_s1_emit;
    logic [PXW-1:0] r_s1_pix;
    logic [SW-1:0] r_s1_slot;
    logic [3:0]    r_s1_k;
    t_tag          r_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else if (w_en) r_s1_valid <= i_s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_emit <= w_emit;
            r_s1_pix  <= i_s_axis_tdata[PXW-1:0];
            r_s1_slot <= w_slot;
            r_s1_k    <= w_k;
            r_s1_tag  <= w_tag;
        end
    end

    // line slot holding the row d above the current one
    logic [SW-1:0] w_dsl [1:KTOP-1];

    always_comb begin
        int t;
        for (int d = 1; d < KTOP; d++) begin
            t = int'(r_s1_slot) - d;
            if (t < 0) t = t + LINES;
            w_dsl[d] = SW'(t);
        end
    end

    // window: column KTOP-1 is the newest, depth 0 the current row
    logic [PXW-1:0] r_win [KTOP][KTOP];

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid) begin
            for (int c = 0; c < KTOP - 1; c++) r_win[c] <= r_win[c+1];
            r_win[KTOP-1][0] <= r_s1_pix;
            for (int d = 1; d < KTOP; d++) r_win[KTOP-1][d] <= w_rdata[w_dsl[d]];
        end
    end

    // active window elements and target rank
    logic [N-1:0]   w_mask;
    logic [7:0]     w_kk;
    logic [N-1:0]   r_s2_mask;
    logic [CNW-1:0] r_s2_rank;

    always_comb begin
        for (int c = 0; c < KTOP; c++) begin
            for (int d = 0; d < KTOP; d++) begin
                w_mask[c*KTOP+d] = (c >= KTOP - int'(r_s1_k)) && (d < int'(r_s1_k));
            end
        end
        w_kk = {4'd0, r_s1_k} * {4'd0, r_s1_k};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_mask <= w_mask;
            r_s2_rank <= CNW'(w_kk >> 1);
        end
    end

    // tag pipe alongside the lanes
    logic r_tv  [PIX_W+1];
    t_tag r_tag [PIX_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= PIX_W; i++) r_tv[i] <= 1'b0;
        end else if (w_en) begin
            r_tv[0] <= r_s1_valid && r_s1_emit;
            for (int i = 1; i <= PIX_W; i++) r_tv[i] <= r_tv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag[0] <= r_s1_tag;
            for (int i = 1; i <= PIX_W; i++) r_tag[i] <= r_tag[i-1];
        end
    end

    // channel lanes
    logic [N-1:0][PIX_W-1:0]    w_lv  [CH_N];
    logic [PIX_W-1:0]           w_med [CH_N];
    logic [CH_N-1:0][PIX_W-1:0] w_med_all;

    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            for (int c = 0; c < KTOP; c++) begin
                for (int d = 0; d < KTOP; d++) begin
                    w_lv[ch][c*KTOP+d] = r_win[c][d][ch*PIX_W +: PIX_W];
                end
            end
            w_med_all[ch] = w_med[ch];
        end
    end

    for (genvar ch = 0; ch < CH_N; ch++) begin : g_lane
        rwm_lane #(
            .N (N)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_vals (w_lv[ch]),
            .i_mask (r_s2_mask),
            .i_rank (r_s2_rank),
            .o_med  (w_med[ch])
        );
    end

    // merge and output queue
    rwm_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_en && r_tv[PIX_W]),
        .i_tag           (r_tag[PIX_W]),
        .i_med           (w_med_all),
        .o_space         (w_en),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(LINES - 1))
        else $error("line slot out of range");

    a_slot_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == '0) |-> (r_slot == '0))
        else $error("line slot out of step with row");

    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tv[PIX_W] && !w_en) |=> (r_tv[PIX_W] && $stable(r_tag[PIX_W])))
        else $error("pipeline tail lost while stalled");

endmodule

>>> design/rwm_linebuf.sv
// Line stores: one memory per buffered line, all read at the current column.
module rwm_linebuf import rwm_pkg::*; #(
    parameter int LINES     = MAX_KERNEL_DEF - 1,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW       = $clog2(MAX_WIDTH),
    localparam int SW       = $clog2(LINES),
    localparam int PXW      = CH_N * PIX_W
) (
    input  logic                       i_clk,
    input  logic                       i_acc,
    input  logic [AW-1:0]              i_addr,
    input  logic [SW-1:0]              i_wslot,
    input  logic [PXW-1:0]             i_wdata,
    output logic [LINES-1:0][PXW-1:0]  o_rdata
);

    for (genvar s = 0; s < LINES; s++) begin : g_line
        logic [PXW-1:0] r_mem [MAX_WIDTH];
        logic [PXW-1:0] r_q;

        // read-first: the slot being overwritten returns its old line
        always_ff @(posedge i_clk) begin
            if (i_acc) begin
                r_q <= r_mem[i_addr];
                if (i_wslot == SW'(s)) begin
                    r_mem[i_addr] <= i_wdata;
                end
            end
        end

        assign o_rdata[s] = r_q;
    end

endmodule

>>> design/rwm_lane.sv
// One channel lane: radix selection of the ranked element, one bit per stage.
module rwm_lane import rwm_pkg::*; #(
    parameter int N     = 49,
    localparam int CNW  = $clog2(N + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [N-1:0][PIX_W-1:0]   i_vals,
    input  logic [N-1:0]              i_mask,
    input  logic [CNW-1:0]            i_rank,
    output logic [PIX_W-1:0]          o_med
);

    logic [N-1:0][PIX_W-1:0] r_vals [PIX_W-1];
    logic [N-1:0]            r_mask [PIX_W-1];
    logic [CNW-1:0]          r_rank [PIX_W-1];
    logic [PIX_W-1:0]        r_res  [PIX_W];

    function automatic logic [CNW-1:0] popc(input logic [N-1:0] v);
        logic [CNW-1:0] acc;
        acc = '0;
        for (int e = 0; e < N; e++) acc = acc + CNW'(v[e]);
        return acc;
    endfunction

    for (genvar s = 0; s < PIX_W; s++) begin : g_st
        localparam int BP = PIX_W - 1 - s;
        logic [N-1:0][PIX_W-1:0] w_vals;
        logic [N-1:0]            w_mask;
        logic [N-1:0]            w_col;
        logic [N-1:0]            w_zero;
        logic [CNW-1:0]          w_rank;
        logic [CNW-1:0]          w_cnt;
        logic [PIX_W-1:0]        w_res;
        logic                    w_bit;

        if (s == 0) begin : g_in
            assign w_vals = i_vals;
            assign w_mask = i_mask;
            assign w_rank = i_rank;
            assign w_res  = '0;
        end else begin : g_prev
            assign w_vals = r_vals[s-1];
            assign w_mask = r_mask[s-1];
            assign w_rank = r_rank[s-1];
            assign w_res  = r_res[s-1];
        end

        // current bit of every candidate
        always_comb begin
            for (int e = 0; e < N; e++) w_col[e] = w_vals[e][BP];
        end

        // candidates with a zero here: if the rank falls among them the bit is zero
        assign w_zero = w_mask & ~w_col;
        assign w_cnt  = popc(w_zero);
        assign w_bit  = (w_rank >= w_cnt);

        always_ff @(posedge i_clk) begin
            if (i_en) r_res[s] <= w_res | (PIX_W'(w_bit) << BP);
        end

        if (s < PIX_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_vals[s] <= w_vals;
                    r_mask[s] <= w_bit ? (w_mask & w_col) : w_zero;
                    r_rank[s] <= w_bit ? (w_rank - w_cnt) : w_rank;
                end
            end
        end
    end

    assign o_med = r_res[PIX_W-1];

endmodule

>>> design/rwm_outq.sv
// Merge stage: joins lane medians with their tag into a two-entry output queue.
module rwm_outq import rwm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_tag                       i_tag,
    input  logic [CH_N-1:0][PIX_W-1:0] i_med,
    output logic                       o_space,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);

    t_res       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_pop;
    t_res       w_head;

    assign w_pop   = o_m_axis_tvalid && i_m_axis_tready;
    assign o_space = (r_cnt != 2'd2) || i_m_axis_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) n_cnt = r_cnt + 2'd1;
        else if (w_pop && !i_push) n_cnt = r_cnt - 2'd1;
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= '{tag: i_tag, med: i_med};
    end

    // head beat
    assign w_head          = r_q[r_rp];
    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, w_head.tag.col, w_head.tag.row,
                              w_head.med[2], w_head.med[1], w_head.med[0]};
    assign o_m_axis_tlast  = w_head.tag.last;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue fill out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_cnt == 2'd2) && !w_pop))
        else $error("push into full output queue");

endmodule

>>> tb/sv/rgb_window_median_filter_tb.sv
// Self-checking testbench for the RGB window median filter: random frames, stalls, checks.
module rgb_window_median_filter_tb;
    import rwm_pkg::*;

    localparam int LINE_N     = MAX_KERNEL_DEF - 1;
    localparam int CYCLE_LIMIT = 3000000;

    // one expected output beat
    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_median_beat;

    // Median predictor and queue of expected beats
    class median_scoreboard;
        bit [23:0]    line_mem [0:LINE_N-1][0:MAX_WIDTH_DEF-1];
        bit [23:0]    win [0:MAX_KERNEL_DEF-1][0:MAX_KERNEL_DEF-1]; // [column][depth]
        int           col_cnt;
        int           row_cnt;
        int           ksize;
        int           width;
        int           height;
        int           errors;
        t_median_beat expected_q[$];

        function new();
            col_cnt = 0;
            row_cnt = 0;
            ksize   = KS_RST;
            width   = WIDTH_RST;
            height  = HEIGHT_RST;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_KERNEL: ksize  = int'(val[KS_W-1:0]);
                CFG_WIDTH:  width  = int'(val);
                CFG_HEIGHT: height = int'(val);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // median of one channel over the (2*half+1)^2 window
        function logic [7:0] chan_median(int half, int shift);
            int vals [0:48];
            int n;
            int v;
            int j;
            n = 0;
            for (int i = MAX_KERNEL_DEF - 1 - 2 * half; i < MAX_KERNEL_DEF; i++)
                for (int d = 0; d <= 2 * half; d++) begin
                    vals[n] = int'((win[i][d] >> shift) & 24'hFF);
                    n++;
                end
            for (int i = 1; i < n; i++) begin
                v = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > v) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = v;
            end
            return 8'(vals[n/2]);
        endfunction

        // accepted input beat
        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
            int w;
            int h;
            int k;
            int half;
            int rr;
            int cc;
            bit [23:0] pix;
            t_median_beat e;
            w = (width == 0) ? 1 : (width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width);
            h = (height == 0) ? 1 : (height > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : height);
            k = (ksize == 0) ? 1 : ksize;
            if (k % 2 == 0) k--;
            if (k > MAX_KERNEL_DEF) k = MAX_KERNEL_DEF;
            half = k / 2;
            pix = {r, g, b};
            if (fs) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= h) row_cnt = 0;
            rr = row_cnt;
            cc = col_cnt;
            // shift window and load the new column
            for (int i = 0; i < MAX_KERNEL_DEF - 1; i++)
                for (int d = 0; d < MAX_KERNEL_DEF; d++)
                    win[i][d] = win[i+1][d];
            win[MAX_KERNEL_DEF-1][0] = pix;
            for (int d = 1; d < MAX_KERNEL_DEF; d++)
                win[MAX_KERNEL_DEF-1][d] = (d <= rr) ? line_mem[(rr - d) % LINE_N][cc] : '0;
            line_mem[rr % LINE_N][cc] = pix;
            if (rr >= 2 * half && cc >= 2 * half) begin
                e.blue  = chan_median(half, 0);
                e.green = chan_median(half, 8);
                e.red   = chan_median(half, 16);
                e.row   = 10'(rr - half);
                e.col   = 10'(cc - half);
                e.last  = (rr == h - 1 && cc == w - 1);
                expected_q.insert(expected_q.size(), e);
            end
            col_cnt = cc + 1;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt = rr + 1;
                if (row_cnt >= h) row_cnt = 0;
            end
        endfunction

        // accepted output beat
        function void check_beat(logic [OUT_DATA_W-1:0] data, logic last);
            t_median_beat e;
            t_median_beat a;
            a.blue  = data[7:0];
            a.green = data[15:8];
            a.red   = data[23:16];
            a.row   = data[33:24];
            a.col   = data[43:34];
            a.last  = last;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat blue=%0d green=%0d red=%0d",
                         $time, a.blue, a.green, a.red);
                $display("%0t: unexpected beat row=%0d col=%0d last=%0b",
                         $time, a.row, a.col, a.last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.blue !== e.blue) begin
                $display("%0t: med_blue exp %0d got %0d", $time, e.blue, a.blue);
                errors++;
            end
            if (a.green !== e.green) begin
                $display("%0t: med_green exp %0d got %0d", $time, e.green, a.green);
                errors++;
            end
            if (a.red !== e.red) begin
                $display("%0t: med_red exp %0d got %0d", $time, e.red, a.red);
                errors++;
            end
            if (a.row !== e.row) begin
                $display("%0t: center_row exp %0d got %0d", $time, e.row, a.row);
                errors++;
            end
            if (a.col !== e.col) begin
                $display("%0t: center_col exp %0d got %0d", $time, e.col, a.col);
                errors++;
            end
            if (a.last !== e.last) begin
                $display("%0t: frame_last exp %0b got %0b", $time, e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;  // pix_blue, pix_green, pix_red
    logic                  i_s_axis_tuser = 1'b0; // frame_start
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;       // med_blue, med_green, med_red,
                                                 // center_row, center_col
    logic                  o_m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [DIM_W-1:0]      i_cfg_data = '0;

    median_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_cnt = 0;
    int cycles = 0;
    int pix_total = 0;

    rgb_window_median_filter u_top (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("rgb_window_median_filter test failed");
            $finish;
        end
    end

    // receiver: random stalls, long hold on request, checks
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_beat(o_m_axis_tdata, o_m_axis_tlast);
        if (hold_req != 0 && hold_cnt == 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // one pixel beat, then a random gap
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, g, b};
        i_s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_pixel(b, g, r, fs);
        pix_total++;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(120 + $urandom_range(7)); // ties are frequent
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // let results drain, then latency margin
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic run_frames(int ks, int w, int h, int npix, int mode);
        drain();
        tx_idle_pct  = (mode == 1) ? 85 : (mode == 3 ? 33 : 0);
        rx_stall_pct = (mode == 2) ? 85 : (mode == 3 ? 33 : 0);
        cfg_write(CFG_KERNEL, DIM_W'(ks));
        cfg_write(CFG_WIDTH, DIM_W'(w));
        cfg_write(CFG_HEIGHT, DIM_W'(h));
        for (int n = 0; n < npix; n++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(),
                       (n == 0) || ($urandom_range(99) < 2));
    endtask

    initial begin
        int w;
        int h;
        int wd;
        int npix;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset geometry (row 0 only, nothing comes out)
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        // zero kernel and zero dimensions act as one: pass-through, every beat last
        drain();
        cfg_write(CFG_KERNEL, 11'd0);
        cfg_write(CFG_WIDTH, 11'd0);
        cfg_write(CFG_HEIGHT, 11'd0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'h0F, 1'b1);
        send_pixel(8'h55, 8'hAA, 8'hF0, 1'b0);
        // 3x3 frame of 3x3: one result
        drain();
        cfg_write(CFG_KERNEL, 11'd3);
        cfg_write(CFG_WIDTH, 11'd3);
        cfg_write(CFG_HEIGHT, 11'd3);
        for (int n = 0; n < 9; n++)
            send_pixel(8'(n * 31), 8'(255 - n * 29), (n % 2) ? 8'hFF : 8'h00, n == 0);
        // frame smaller than the largest window
        run_frames(7, 2, 2, 4, 0);

        // random frames across kernel sizes and idle modes; the first one
        // runs against a long receiver hold so the block fills up
        for (int p = 0; pix_total < 690; p++) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 12);
            wd = w;
            if (p % 5 == 4) wd = $urandom_range(2047);
            if (p == 0) begin
                wd = 16;
                h = 12;
            end
            w = (wd == 0) ? 1 : (wd > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : wd);
            npix = w * h * $urandom_range(1, 2);
            if (npix > 300) npix = 300;
            if (npix > 690 - pix_total) npix = 690 - pix_total;
            if (p == 0) hold_req = 400;
            run_frames(p % 8, wd, h, npix, p % 4);
        end

        // largest window with mixed idling
        run_frames(7, 12, 10, 240, 3);

        drain();
        if (sb.errors == 0)
            $display("rgb_window_median_filter test passed");
        else
            $display("rgb_window_median_filter test failed");
        $finish;
    end
endmodule
